// ===== design/bresenham_line_glyph_stepper_defines.svh =====
// assertion macros shared by the line stepper checker
// no dependencies
`ifndef BRESENHAM_LINE_GLYPH_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_GLYPH_STEPPER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define BLGS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define BLGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/blgs_pkg.sv =====
// types, constants and codes for the bresenham line glyph stepper
// no dependencies
package blgs_pkg;

   localparam int COORD_BITS = 6;
   localparam int GRID_BITS  = COORD_BITS + 1;
   // error term holds dx - dy plus one step of either delta
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [GRID_BITS-1:0] GRID_RESET = GRID_BITS'(1 << COORD_BITS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      GLYPH_HORIZ = 2'd0,
      GLYPH_VERT  = 2'd1,
      GLYPH_RISE  = 2'd2,
      GLYPH_FALL  = 2'd3
   } glyph_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cell_x;
      logic [COORD_BITS-1:0] cell_y;
      glyph_type             glyph;
      logic                  in_grid;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic at_target;
      logic last_step;
   } status_type;

endpackage

// ===== design/blgs_ctrl.sv =====
// controller for the line stepper: request/response handshake and step sequencing
// depends on blgs_pkg
module blgs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  blgs_pkg::status_type status,
   output blgs_pkg::cmd_type    cmd
);

   blgs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blgs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         blgs_pkg::ST_IDLE: begin
            if (req_valid) state_in = blgs_pkg::ST_RUN;
         end
         blgs_pkg::ST_RUN: begin
            // a point segment leaves at once, otherwise leave on the final step
            if (status.at_target || (cmd.step && status.last_step))
               state_in = blgs_pkg::ST_IDLE;
         end
         default: state_in = blgs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         blgs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         blgs_pkg::ST_RUN: begin
            cmd.step = !status.at_target && (!rsp_valid_ff || rsp_ready);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      rsp_valid_in = cmd.step || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/blgs_dp.sv =====
// datapath for the line stepper: grid registers, bresenham step unit, response register
// depends on blgs_pkg
module blgs_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [blgs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [blgs_pkg::GRID_BITS-1:0]        csr_wdata,
   input  blgs_pkg::req_type                     req_payload,
   input  blgs_pkg::cmd_type                     cmd,
   output blgs_pkg::status_type                  status,
   output blgs_pkg::rsp_type                     rsp_payload
);

   localparam int CB = blgs_pkg::COORD_BITS;
   localparam int EB = blgs_pkg::ERR_BITS;

   logic [blgs_pkg::GRID_BITS-1:0] grid_w_ff, grid_h_ff;

   logic [CB-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CB-1:0]        tgt_x_ff, tgt_y_ff;
   logic [CB-1:0]        dx_ff, dx_in;
   logic signed [EB-1:0] dyn_ff, dyn_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic                 dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   blgs_pkg::rsp_type    rsp_ff, rsp_in;

   logic [CB-1:0]        dy_abs;
   logic signed [EB-1:0] dx_ext;
   logic signed [EB:0]   e2;
   logic                 move_x, move_y;
   logic signed [EB-1:0] add_x, add_y;
   logic [CB-1:0]        nxt_x, nxt_y;
   blgs_pkg::glyph_type  glyph;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= blgs_pkg::GRID_RESET;
         grid_h_ff <= blgs_pkg::GRID_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            blgs_pkg::CSR_GRID_WIDTH:  grid_w_ff <= csr_wdata;
            blgs_pkg::CSR_GRID_HEIGHT: grid_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // one bresenham step from the current cursor
   always_comb begin
      dx_ext = $signed({{(EB-CB){1'b0}}, dx_ff});
      e2     = $signed({err_ff, 1'b0});
      move_x = e2 >= $signed({dyn_ff[EB-1], dyn_ff});
      move_y = e2 <= $signed({1'b0, dx_ext});
      add_x  = move_x ? dyn_ff : '0;
      add_y  = move_y ? dx_ext : '0;
      nxt_x  = move_x ? (dir_x_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1) : cur_x_ff;
      nxt_y  = move_y ? (dir_y_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1) : cur_y_ff;
      if (move_x && move_y)
         glyph = (dir_x_ff == dir_y_ff) ? blgs_pkg::GLYPH_RISE : blgs_pkg::GLYPH_FALL;
      else if (move_x)
         glyph = blgs_pkg::GLYPH_HORIZ;
      else
         glyph = blgs_pkg::GLYPH_VERT;
   end

   // segment setup and cursor update
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      dx_in    = dx_ff;
      dyn_in   = dyn_ff;
      err_in   = err_ff;
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      dy_abs   = (req_payload.y_end > req_payload.y_start)
                 ? req_payload.y_end - req_payload.y_start
                 : req_payload.y_start - req_payload.y_end;
      if (cmd.load) begin
         cur_x_in = req_payload.x_start;
         cur_y_in = req_payload.y_start;
         dx_in    = (req_payload.x_end > req_payload.x_start)
                    ? req_payload.x_end - req_payload.x_start
                    : req_payload.x_start - req_payload.x_end;
         dyn_in   = -$signed({{(EB-CB){1'b0}}, dy_abs});
         err_in   = $signed({{(EB-CB){1'b0}}, dx_in}) + dyn_in;
         // equal coordinates count as stepping downward
         dir_x_in = !(req_payload.x_start < req_payload.x_end);
         dir_y_in = !(req_payload.y_start < req_payload.y_end);
      end else if (cmd.step) begin
         cur_x_in = nxt_x;
         cur_y_in = nxt_y;
         err_in   = err_ff + add_x + add_y;
      end
   end

   always_comb begin
      rsp_in         = rsp_ff;
      if (cmd.step) begin
         rsp_in.cell_x  = cur_x_ff;
         rsp_in.cell_y  = cur_y_ff;
         rsp_in.glyph   = glyph;
         rsp_in.in_grid = ({1'b0, cur_x_ff} < grid_w_ff) && ({1'b0, cur_y_ff} < grid_h_ff);
         rsp_in.last    = status.last_step;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      dx_ff    <= dx_in;
      dyn_ff   <= dyn_in;
      err_ff   <= err_in;
      dir_x_ff <= dir_x_in;
      dir_y_ff <= dir_y_in;
      rsp_ff   <= rsp_in;
      if (cmd.load) begin
         tgt_x_ff <= req_payload.x_end;
         tgt_y_ff <= req_payload.y_end;
      end
   end

   assign status.at_target = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
   assign status.last_step = (nxt_x == tgt_x_ff) && (nxt_y == tgt_y_ff);
   assign rsp_payload      = rsp_ff;

endmodule

// ===== design/bresenham_line_glyph_stepper.sv =====
// channel   ports                           moves
// req       req_valid req_ready req_payload one segment, start and end point
// rsp       rsp_valid rsp_ready rsp_payload one cell per step with glyph and flags
// csr       csr_wr_en csr_index csr_wdata   grid width, grid height
//
// a point segment (start equal to end) gives no response
// one step per cycle while the response register is not stalled, through the single bresenham step unit in the datapath
// a stalled response register holds stepping; the next request is taken
// while the final response still waits
// reset is synchronous; grid width and height come out of reset at 64
module bresenham_line_glyph_stepper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  blgs_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output blgs_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [blgs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [blgs_pkg::GRID_BITS-1:0]    csr_wdata
);

   blgs_pkg::cmd_type    cmd;
   blgs_pkg::status_type status;

   blgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   blgs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/blgs_checker.sv =====
// port-level checks for the line stepper, bound to the top level
// depends on blgs_pkg and bresenham_line_glyph_stepper_defines.svh
`include "bresenham_line_glyph_stepper_defines.svh"

module blgs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input blgs_pkg::req_type                 req_payload,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input blgs_pkg::rsp_type                 rsp_payload,
   input logic                              csr_wr_en,
   input logic [blgs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input logic [blgs_pkg::GRID_BITS-1:0]    csr_wdata
);

   // a stalled response keeps its valid and payload
   `BLGS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // a taken request keeps the block busy in the following cycle
   `BLGS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while a segment is loading")

   // a pending non-final cell means the segment is still stepping
   `BLGS_ASSERT_IMP(a_no_req_mid_segment, clock, reset, rsp_valid && !rsp_payload.last, !req_ready, "request ready before segment end")

endmodule

bind bresenham_line_glyph_stepper blgs_checker u_blgs_checker (.*);
